[sv/vlhe_pkg.sv]
// Package for the variable-length Hamming encoder: transfer item types,
// field widths and the fixed bit-scatter and parity functions.
// No dependencies.
package vlhe_pkg;

	// Field widths fixed by the item format.
	localparam int DATA_W      = 57;
	localparam int LEN_W       = 6;
	localparam int CW_W        = 63;
	localparam int PCNT_W      = 3;
	localparam int MAX_PARITY  = 6;

	// Default for the largest message length the block accepts.
	localparam int MAX_DATA_BITS_DEF = 57;

	// One message item on the input channel.
	typedef struct packed {
		logic [DATA_W-1:0] data_word;
		logic [LEN_W-1:0]  data_length;
	} msg_item_t;

	// One encoded item on the output channel.
	typedef struct packed {
		logic [CW_W-1:0]   codeword;
		logic [LEN_W-1:0]  code_length;
		logic [PCNT_W-1:0] parity_count;
	} code_item_t;

	// Places data bits on the non-power-of-two codeword positions in
	// ascending order. The mapping is fixed, so this is pure wiring.
	function automatic logic [CW_W-1:0] scatter(input logic [DATA_W-1:0] data);
		logic [CW_W-1:0] cw;
		int              k;
		cw = '0;
		k  = 0;
		for (int pos = 1; pos <= CW_W; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				if (k < DATA_W) begin
					cw[pos-1] = data[k];
				end
				k++;
			end
		end
		return cw;
	endfunction

	// Even parity of every position that has the given index bit set.
	// Parity positions are still zero in the input word.
	function automatic logic [MAX_PARITY-1:0] parity(input logic [CW_W-1:0] cw);
		logic [MAX_PARITY-1:0] par;
		par = '0;
		for (int b = 0; b < MAX_PARITY; b++) begin
			for (int pos = 1; pos <= CW_W; pos++) begin
				if (((pos >> b) & 1) != 0) begin
					par[b] = par[b] ^ cw[pos-1];
				end
			end
		end
		return par;
	endfunction

endpackage

[sv/vlhe_encode.sv]
// Combinational Hamming encode of one message: length clamp, parity count,
// bit scatter and parity XOR trees.
// Depends on vlhe_pkg.
module vlhe_encode #(
	parameter int MAX_DATA_BITS = vlhe_pkg::MAX_DATA_BITS_DEF
) (
	input  logic [MAX_DATA_BITS-1:0]     data,
	input  logic [vlhe_pkg::LEN_W-1:0]   data_length,
	output vlhe_pkg::code_item_t         result
);
	import vlhe_pkg::*;

	logic [LEN_W-1:0]      m;
	logic [PCNT_W-1:0]     p;
	logic [DATA_W-1:0]     data_ext;
	logic [DATA_W-1:0]     data_used;
	logic [CW_W-1:0]       cw_data;
	logic [MAX_PARITY-1:0] par;
	logic [CW_W-1:0]       cw_full;

	// Clamp the length into one up to the largest message length.
	always_comb begin
		if (data_length == '0) begin
			m = LEN_W'(1);
		end else if (data_length > LEN_W'(MAX_DATA_BITS)) begin
			m = LEN_W'(MAX_DATA_BITS);
		end else begin
			m = data_length;
		end
	end

	// Smallest parity count p with 2^p >= p + m + 1.
	always_comb begin
		priority if (m <= LEN_W'(1)) begin
			p = PCNT_W'(2);
		end else if (m <= LEN_W'(4)) begin
			p = PCNT_W'(3);
		end else if (m <= LEN_W'(11)) begin
			p = PCNT_W'(4);
		end else if (m <= LEN_W'(26)) begin
			p = PCNT_W'(5);
		end else begin
			p = PCNT_W'(6);
		end
	end

	// Drop the message bits at or above the effective length.
	always_comb begin
		data_ext = DATA_W'(data);
		for (int k = 0; k < DATA_W; k++) begin
			data_used[k] = data_ext[k] & (k < int'(m));
		end
	end

	// Scatter, then insert parity bits. Parity bits beyond p come out as zero
	// on their own, as every position they cover lies above the code length.
	always_comb begin
		cw_data = scatter(data_used);
		par     = parity(cw_data);
		cw_full = cw_data;
		for (int b = 0; b < MAX_PARITY; b++) begin
			cw_full[(1 << b) - 1] = par[b];
		end
	end

	assign result.codeword     = cw_full;
	assign result.code_length  = m + LEN_W'(p);
	assign result.parity_count = p;

endmodule

[sv/variable_length_hamming_encoder_top.sv]
// Top level of the variable-length Hamming encoder: input register, encode
// logic and result register with valid/ready flow control.
// Depends on vlhe_pkg and vlhe_encode.
//
//  channel | direction | payload type | handshake
//  msg     | in        | msg_item_t   | msg_valid / msg_ready
//  code    | out       | code_item_t  | code_valid / code_ready
//
// One item is accepted per cycle while msg_ready is high. The result is
// presented on code from the result register, loaded from the input register.
// Reset clears only the two stage valid flags.
// A stalled result holds in the result register while the input register
// can still take one more item; msg_ready drops once both stages are full
// and code_ready is low.
module variable_length_hamming_encoder_top #(
	parameter int MAX_DATA_BITS = vlhe_pkg::MAX_DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_ready,
	input  vlhe_pkg::msg_item_t  msg,
	output logic                 code_valid,
	input  logic                 code_ready,
	output vlhe_pkg::code_item_t code
);
	import vlhe_pkg::*;

	logic                     valid_s1;
	logic [MAX_DATA_BITS-1:0] data_s1;
	logic [LEN_W-1:0]         length_s1;
	logic                     valid_s2;
	code_item_t               result_s2;
	code_item_t               encoded;
	logic                     free_s2;
	logic                     load_s2;

	// Stage advance conditions.
	assign free_s2   = !valid_s2 || code_ready;
	assign load_s2   = valid_s1 && free_s2;
	assign msg_ready = !valid_s1 || free_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg_ready) begin
			valid_s1 <= msg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_valid && msg_ready) begin
			data_s1   <= msg.data_word[MAX_DATA_BITS-1:0];
			length_s1 <= msg.data_length;
		end
	end

	// Encode logic between the two registers.
	vlhe_encode #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_encode (
		.data        (data_s1),
		.data_length (length_s1),
		.result      (encoded)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= encoded;
		end
	end

	assign code_valid = valid_s2;
	assign code       = result_s2;

	// An item held in the input register keeps its contents while blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !free_s2 |=> valid_s1 && $stable(data_s1) && $stable(length_s1))
		else $error("input register changed while blocked");

	// No codeword bit is set at or above the code length.
	a_cw_len: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> ((64'(code.codeword) >> code.code_length) == 64'd0))
		else $error("codeword bits beyond code length");

	// The parity count covers the code length.
	a_pcnt: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> ((7'd1 << code.parity_count) > {1'b0, code.code_length}))
		else $error("parity count too small for code length");

endmodule
